// ===== design/wsea_pkg.sv =====
package wsea_pkg;

    localparam int WINDOW     = 30;
    localparam int DPE_W      = 20;
    localparam int TMO_W      = 32;
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 24;
    localparam int DIST_W     = 48;
    localparam int EC_W       = 32;
    localparam int SUM_W      = TIME_W + $clog2(WINDOW);
    localparam int CNT_W      = $clog2(WINDOW + 2);
    localparam int NUM_SCALE  = 1000 * WINDOW;
    localparam int SCALE_W    = $clog2(NUM_SCALE + 1);
    localparam int NUM_W      = DPE_W + SCALE_W;
    localparam int DIVCNT_W   = $clog2(NUM_W + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_EDGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TIMEOUT  = 1'd1;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [DPE_W-1:0]   DPE_RESET = 20'd29259;
    localparam logic [TMO_W-1:0]   TMO_RESET = 32'd1000000;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== design/wsea_if.sv =====
interface wsea_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [wsea_pkg::TIME_W-1:0]  time_us;

    modport source (output valid, output kind, output time_us, input ready);
    modport sink   (input valid, input kind, input time_us, output ready);
endinterface

interface wsea_out_if;
    logic                         valid;
    logic                         ready;
    logic [wsea_pkg::SPEED_W-1:0] speed_mm_per_s;
    logic [wsea_pkg::DIST_W-1:0]  distance_um;

    modport source (output valid, output speed_mm_per_s, output distance_um, input ready);
    modport sink   (input valid, input speed_mm_per_s, input distance_um, output ready);
endinterface

// ===== design/wsea_cell.sv =====
module wsea_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  logic [wsea_pkg::TIME_W-1:0] din,
    output logic [wsea_pkg::TIME_W-1:0] dout
);

    logic [wsea_pkg::TIME_W-1:0] interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= '0;
        end
        else if (shift)
        begin
            interval_reg <= din;
        end
    end

    assign dout = interval_reg;

endmodule

// ===== design/wsea_div.sv =====
module wsea_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wsea_pkg::NUM_W-1:0]   numer,
    input  logic [wsea_pkg::SUM_W-1:0]   divisor,
    output logic                         done,
    output logic [wsea_pkg::SPEED_W-1:0] quot
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [wsea_pkg::DIVCNT_W-1:0]   cnt_reg;
    logic [wsea_pkg::NUM_W-1:0]      num_reg;
    logic [wsea_pkg::NUM_W-1:0]      q_reg;
    logic [wsea_pkg::SUM_W-1:0]      den_reg;
    logic [wsea_pkg::SUM_W-1:0]      rem_reg;
    logic [wsea_pkg::SUM_W:0]        partial;
    logic [wsea_pkg::SUM_W+1:0]      diff;
    logic                            ge;
    logic [wsea_pkg::SUM_W-1:0]      rem_next;

    assign partial  = {rem_reg, num_reg[wsea_pkg::NUM_W-1]};
    assign diff     = {1'b0, partial} - {2'b00, den_reg};
    assign ge       = !diff[wsea_pkg::SUM_W+1];
    assign rem_next = ge ? diff[wsea_pkg::SUM_W-1:0] : partial[wsea_pkg::SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == wsea_pkg::DIVCNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= wsea_pkg::DIVCNT_W'(wsea_pkg::NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - wsea_pkg::DIVCNT_W'(1);
                if (cnt_reg == wsea_pkg::DIVCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[wsea_pkg::NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[wsea_pkg::NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = (q_reg[wsea_pkg::NUM_W-1:wsea_pkg::SPEED_W] != '0)
                  ? wsea_pkg::SPEED_MAX : q_reg[wsea_pkg::SPEED_W-1:0];

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("divider done without a running division");

    property p_no_start_while_busy;
        @(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg;
    endproperty
    a_no_start_while_busy: assert property (p_no_start_while_busy)
        else $error("divider restarted while busy");

    property p_count_steps;
        @(posedge clk) disable iff (!rst_n)
        (busy_reg && !start) |=> (cnt_reg == $past(cnt_reg) - wsea_pkg::DIVCNT_W'(1));
    endproperty
    a_count_steps: assert property (p_count_steps)
        else $error("divider step count skipped");

endmodule

// ===== design/wheel_speed_edge_averager.sv =====
// channel   modport  transfer moves
// in_ch     sink     kind, time_us
// out_ch    source   speed_mm_per_s, distance_um (one per tick)
// cfg       write    cfg_index, cfg_data when cfg_we
//
// an edge item shifts the interval through the cell row, then updates the sum in ST_SUM
// a tick runs ST_CALC then ST_DONE, with ST_DIV between when the speed is updated: the
// bit-serial divider steps once per numerator bit (35)
// a tick waits in its last step while the output register is still full
// asynchronous active-low reset covers control, counts, sum and cells, no clearing pass
module wheel_speed_edge_averager (
    input  logic                              clk,
    input  logic                              rst_n,
    wsea_in_if.sink                           in_ch,
    wsea_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [wsea_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wsea_pkg::CFG_DATA_W-1:0]   cfg_data
);

    wsea_pkg::state_t state_reg, state_next;

    logic [wsea_pkg::DPE_W-1:0]   dpe_reg;
    logic [wsea_pkg::TMO_W-1:0]   tmo_reg;
    logic [wsea_pkg::TIME_W-1:0]  ring_q [wsea_pkg::WINDOW];
    logic [wsea_pkg::TIME_W-1:0]  last_edge_reg;
    logic [wsea_pkg::EC_W-1:0]    edge_count_reg;
    logic [wsea_pkg::CNT_W-1:0]   new_count_reg;
    logic [wsea_pkg::SUM_W-1:0]   sum_reg;
    logic [wsea_pkg::TIME_W-1:0]  iv_reg;
    logic [wsea_pkg::TIME_W-1:0]  oldest_reg;
    logic [wsea_pkg::TIME_W-1:0]  tick_time_reg;
    logic                         timeout_reg;
    logic [wsea_pkg::SPEED_W-1:0] speed_reg;
    logic [wsea_pkg::DIST_W-1:0]  dist_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [wsea_pkg::SPEED_W-1:0] out_speed_reg;
    logic [wsea_pkg::DIST_W-1:0]  out_dist_reg;

    logic                         edge_acc;
    logic                         tick_acc;
    logic [wsea_pkg::TIME_W-1:0]  iv;
    logic                         timeout_now;
    logic                         need_update;
    logic                         div_start;
    logic                         div_done;
    logic [wsea_pkg::SPEED_W-1:0] div_quot;
    logic                         out_load;
    logic [wsea_pkg::EC_W+wsea_pkg::DPE_W-1:0] dist_prod;
    logic [wsea_pkg::NUM_W-1:0]   num_prod;

    assign in_ch.ready = (state_reg == wsea_pkg::ST_IDLE);
    assign edge_acc    = in_ch.valid && in_ch.ready && (in_ch.kind == wsea_pkg::KIND_EDGE);
    assign tick_acc    = in_ch.valid && in_ch.ready && (in_ch.kind == wsea_pkg::KIND_TICK);
    assign iv          = in_ch.time_us - last_edge_reg;
    assign timeout_now = (tick_time_reg - last_edge_reg) > tmo_reg;
    assign need_update = new_count_reg > wsea_pkg::CNT_W'(wsea_pkg::WINDOW);
    assign dist_prod   = edge_count_reg * dpe_reg;
    assign num_prod    = wsea_pkg::NUM_W'(dpe_reg) * wsea_pkg::NUM_W'(wsea_pkg::NUM_SCALE);

    for (genvar i = 0; i < wsea_pkg::WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            wsea_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (edge_acc),
                .din   (iv),
                .dout  (ring_q[i])
            );
        end
        else
        begin : g_body
            wsea_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (edge_acc),
                .din   (ring_q[i-1]),
                .dout  (ring_q[i])
            );
        end
    end

    wsea_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .numer   (num_prod),
        .divisor (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        div_start      = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ch.ready;
        case (state_reg)
            wsea_pkg::ST_IDLE:
            begin
                if (edge_acc)
                begin
                    state_next = wsea_pkg::ST_SUM;
                end
                else if (tick_acc)
                begin
                    state_next = wsea_pkg::ST_CALC;
                end
            end
            wsea_pkg::ST_SUM:
            begin
                state_next = wsea_pkg::ST_IDLE;
            end
            wsea_pkg::ST_CALC:
            begin
                if (need_update)
                begin
                    div_start  = 1'b1;
                    state_next = wsea_pkg::ST_DIV;
                end
                else
                begin
                    state_next = wsea_pkg::ST_DONE;
                end
            end
            wsea_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = wsea_pkg::ST_DONE;
                end
            end
            wsea_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = wsea_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wsea_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsea_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpe_reg <= wsea_pkg::DPE_RESET;
            tmo_reg <= wsea_pkg::TMO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wsea_pkg::REG_DIST_PER_EDGE: dpe_reg <= cfg_data[wsea_pkg::DPE_W-1:0];
                wsea_pkg::REG_STOP_TIMEOUT:  tmo_reg <= cfg_data[wsea_pkg::TMO_W-1:0];
                default:                     tmo_reg <= tmo_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg  <= '0;
            edge_count_reg <= '0;
            new_count_reg  <= '0;
            sum_reg        <= '0;
            speed_reg      <= '0;
        end
        else
        begin
            if (edge_acc)
            begin
                last_edge_reg  <= in_ch.time_us;
                edge_count_reg <= edge_count_reg + wsea_pkg::EC_W'(1);
                if (!need_update)
                begin
                    new_count_reg <= new_count_reg + wsea_pkg::CNT_W'(1);
                end
            end
            if (state_reg == wsea_pkg::ST_SUM)
            begin
                sum_reg <= sum_reg - wsea_pkg::SUM_W'(oldest_reg) + wsea_pkg::SUM_W'(iv_reg);
            end
            if (state_reg == wsea_pkg::ST_CALC)
            begin
                if (need_update)
                begin
                    new_count_reg <= '0;
                end
                else if (timeout_now)
                begin
                    speed_reg <= '0;
                end
            end
            if (state_reg == wsea_pkg::ST_DIV && div_done)
            begin
                speed_reg <= timeout_reg ? '0 : div_quot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_acc)
        begin
            iv_reg     <= iv;
            oldest_reg <= ring_q[wsea_pkg::WINDOW-1];
        end
        if (tick_acc)
        begin
            tick_time_reg <= in_ch.time_us;
        end
        if (state_reg == wsea_pkg::ST_CALC)
        begin
            dist_reg    <= dist_prod[wsea_pkg::DIST_W-1:0];
            timeout_reg <= timeout_now;
        end
        if (out_load)
        begin
            out_speed_reg <= speed_reg;
            out_dist_reg  <= dist_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.speed_mm_per_s = out_speed_reg;
    assign out_ch.distance_um    = out_dist_reg;

    property p_new_count_bound;
        @(posedge clk) disable iff (!rst_n)
        edge_acc |=> (new_count_reg <= wsea_pkg::CNT_W'(wsea_pkg::WINDOW + 1));
    endproperty
    a_new_count_bound: assert property (p_new_count_bound)
        else $error("new interval count above window plus one");

    property p_edge_count_step;
        @(posedge clk) disable iff (!rst_n)
        edge_acc |=> (edge_count_reg == $past(edge_count_reg) + wsea_pkg::EC_W'(1));
    endproperty
    a_edge_count_step: assert property (p_edge_count_step)
        else $error("edge count did not advance on an edge");

    property p_tick_holds_input;
        @(posedge clk) disable iff (!rst_n)
        tick_acc |=> !in_ch.ready;
    endproperty
    a_tick_holds_input: assert property (p_tick_holds_input)
        else $error("input taken while a tick is in work");

    property p_result_from_done;
        @(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == wsea_pkg::ST_IDLE);
    endproperty
    a_result_from_done: assert property (p_result_from_done)
        else $error("result load did not show a valid transfer");

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 50;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 380;

    typedef struct packed {
        logic [wsea_pkg::SPEED_W-1:0] speed;
        logic [wsea_pkg::DIST_W-1:0]  distance;
    } reading_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [wsea_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wsea_pkg::CFG_DATA_W-1:0] cfg_data;

    wsea_in_if  in_ch ();
    wsea_out_if out_ch ();

    wheel_speed_edge_averager u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    reading_t    pending_readings[$];
    reading_t    got_reading;
    reading_t    want_reading;
    int          errors = 0;
    int          items_sent = 0;
    int          readings_checked = 0;
    int          speed_updates = 0;
    int          timeouts_hit = 0;
    int          quiet_cycles = 0;
    bit          stall_en;
    logic [31:0] tnow;

    // tachometer state as the block should hold it
    logic [wsea_pkg::TIME_W-1:0]  iv_ring [wsea_pkg::WINDOW];
    int                           iv_ptr;
    logic [63:0]                  iv_sum;
    int                           fresh_ivs;
    logic [wsea_pkg::TIME_W-1:0]  last_edge_us;
    logic [wsea_pkg::EC_W-1:0]    edges_seen;
    logic [wsea_pkg::SPEED_W-1:0] cur_speed;
    logic [wsea_pkg::DPE_W-1:0]   cfg_dpe;
    logic [wsea_pkg::TMO_W-1:0]   cfg_timeout;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [wsea_pkg::SPEED_W-1:0] window_rate();
        logic [63:0] num;
        logic [63:0] q;
        num = 64'(cfg_dpe) * 64'(wsea_pkg::NUM_SCALE);
        if (iv_sum == 0)
            return wsea_pkg::SPEED_MAX;
        q = num / iv_sum;
        return (q > 64'(wsea_pkg::SPEED_MAX)) ? wsea_pkg::SPEED_MAX
                                               : q[wsea_pkg::SPEED_W-1:0];
    endfunction

    task automatic model_tach(input logic kind, input logic [wsea_pkg::TIME_W-1:0] t);
        logic [wsea_pkg::TIME_W-1:0] gap;
        logic [63:0]                 travel;
        reading_t                    r;
        gap = t - last_edge_us;
        if (kind == wsea_pkg::KIND_EDGE)
        begin
            iv_sum = iv_sum - 64'(iv_ring[iv_ptr]) + 64'(gap);
            iv_ring[iv_ptr] = gap;
            iv_ptr = (iv_ptr + 1) % wsea_pkg::WINDOW;
            last_edge_us = t;
            edges_seen = edges_seen + 1'b1;
            if (fresh_ivs <= wsea_pkg::WINDOW)
                fresh_ivs++;
        end
        else
        begin
            travel = 64'(edges_seen) * 64'(cfg_dpe);
            if (fresh_ivs > wsea_pkg::WINDOW)
            begin
                cur_speed = window_rate();
                fresh_ivs = 0;
                speed_updates++;
            end
            if (gap > cfg_timeout)
            begin
                cur_speed = '0;
                timeouts_hit++;
            end
            r.speed    = cur_speed;
            r.distance = travel[wsea_pkg::DIST_W-1:0];
            pending_readings.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t ns: %s", $realtime, msg);
    endtask

    task automatic send_item(input logic kind, input logic [wsea_pkg::TIME_W-1:0] t);
        @(negedge clk);
        while (stall_en && $urandom_range(99) < 9)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kind;
        in_ch.time_us <= t;
        do
            @(posedge clk);
        while (!in_ch.ready);
        model_tach(kind, t);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wsea_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wsea_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == wsea_pkg::REG_DIST_PER_EDGE)
            cfg_dpe = data[wsea_pkg::DPE_W-1:0];
        else if (idx == wsea_pkg::REG_STOP_TIMEOUT)
            cfg_timeout = data[wsea_pkg::TMO_W-1:0];
    endtask

    // a run of edges, with a tick now and then among them, ending in a tick
    task automatic edge_burst(input int n, input logic [31:0] iv_lo, input logic [31:0] iv_hi);
        logic [31:0] step;
        for (int i = 0; i < n; i++)
        begin
            step = (iv_hi == '1) ? $urandom : $urandom_range(iv_hi, iv_lo);
            tnow = tnow + step;
            send_item(wsea_pkg::KIND_EDGE, tnow);
            if ($urandom_range(7) == 0)
                send_item(wsea_pkg::KIND_TICK, tnow + $urandom_range(50));
        end
        case ($urandom_range(4))
            0: send_item(wsea_pkg::KIND_TICK, tnow + cfg_timeout + 32'd1 + $urandom_range(3));
            1: send_item(wsea_pkg::KIND_TICK, tnow + cfg_timeout);
            default: send_item(wsea_pkg::KIND_TICK, tnow + $urandom_range(20000));
        endcase
    endtask

    task automatic test_zero_intervals();
        send_item(wsea_pkg::KIND_TICK, 32'd0);
        for (int i = 0; i <= wsea_pkg::WINDOW; i++)
            send_item(wsea_pkg::KIND_EDGE, 32'd0);
        send_item(wsea_pkg::KIND_TICK, 32'd100);
        send_item(wsea_pkg::KIND_TICK, 32'hFFFF_FFFF);
        send_item(wsea_pkg::KIND_EDGE, 32'hFFFF_FFFF);
        send_item(wsea_pkg::KIND_TICK, 32'd5);
        tnow = 32'd5;
    endtask

    task automatic test_register_extremes();
        settle();
        write_reg(wsea_pkg::REG_DIST_PER_EDGE, 32'hFFFF_FFFF);
        write_reg(wsea_pkg::REG_STOP_TIMEOUT, 32'hFFFF_FFFF);
        edge_burst(wsea_pkg::WINDOW + 1, 32'd1, 32'd3);
        settle();
        write_reg(wsea_pkg::REG_DIST_PER_EDGE, 32'd1);
        write_reg(wsea_pkg::REG_STOP_TIMEOUT, 32'd1);
        tnow = tnow + 32'd1000;
        send_item(wsea_pkg::KIND_EDGE, tnow);
        send_item(wsea_pkg::KIND_TICK, tnow + 32'd1);
        send_item(wsea_pkg::KIND_TICK, tnow + 32'd2);
        edge_burst(wsea_pkg::WINDOW + 1, 32'd10, 32'd40);
        settle();
        // zero travel per edge, upper data bits set
        write_reg(wsea_pkg::REG_DIST_PER_EDGE, 32'hFFF0_0000);
        edge_burst(wsea_pkg::WINDOW + 2, 32'd100, 32'd1000);
        settle();
        write_reg(wsea_pkg::REG_DIST_PER_EDGE, 32'(wsea_pkg::DPE_RESET));
        write_reg(wsea_pkg::REG_STOP_TIMEOUT, wsea_pkg::TMO_RESET);
    endtask

    task automatic test_random_traffic();
        int phase;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle();
            write_reg(wsea_pkg::REG_DIST_PER_EDGE,
                      ($urandom_range(3) == 0) ? 32'd29259 : $urandom);
            case ($urandom_range(2))
                0: write_reg(wsea_pkg::REG_STOP_TIMEOUT, $urandom);
                1: write_reg(wsea_pkg::REG_STOP_TIMEOUT, $urandom_range(5000000, 20000));
                default: write_reg(wsea_pkg::REG_STOP_TIMEOUT, $urandom_range(400000, 1));
            endcase
            stall_en = (phase != 2);
            repeat ($urandom_range(2, 1))
            begin
                case ($urandom_range(3))
                    0: edge_burst($urandom_range(wsea_pkg::WINDOW + 6, wsea_pkg::WINDOW + 1),
                                  32'd0, 32'd3);
                    1: edge_burst($urandom_range(wsea_pkg::WINDOW + 6, wsea_pkg::WINDOW + 1),
                                  32'd200, 32'd5000);
                    2: edge_burst($urandom_range(wsea_pkg::WINDOW + 6, wsea_pkg::WINDOW - 4),
                                  32'd5000, 32'd300000);
                    default: edge_burst($urandom_range(wsea_pkg::WINDOW + 6,
                                                       wsea_pkg::WINDOW + 1), 32'd0, '1);
                endcase
            end
            phase++;
        end
        stall_en = 1'b1;
    endtask

    task automatic test_noise();
        repeat (60)
        begin
            if ($urandom_range(1) == 0)
                tnow = $urandom;
            else
                tnow = tnow + $urandom_range(2000);
            send_item($urandom_range(1) ? wsea_pkg::KIND_TICK : wsea_pkg::KIND_EDGE, tnow);
        end
    endtask

    always @(negedge clk)
        out_ch.ready <= !(stall_en && $urandom_range(99) < 9);

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got_reading.speed    = out_ch.speed_mm_per_s;
            got_reading.distance = out_ch.distance_um;
            if (pending_readings.size() == 0)
            begin
                report_mismatch($sformatf("unexpected reading speed %0d distance %0d",
                                          got_reading.speed, got_reading.distance));
            end
            else
            begin
                want_reading = pending_readings.pop_front();
                if (got_reading.speed !== want_reading.speed)
                    report_mismatch($sformatf("speed %0d, expected %0d",
                                              got_reading.speed, want_reading.speed));
                if (got_reading.distance !== want_reading.distance)
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              got_reading.distance, want_reading.distance));
                readings_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = wsea_pkg::KIND_EDGE;
        in_ch.time_us = '0;
        out_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = wsea_pkg::REG_DIST_PER_EDGE;
        cfg_data      = '0;
        stall_en      = 1'b1;
        tnow          = '0;
        for (int i = 0; i < wsea_pkg::WINDOW; i++)
            iv_ring[i] = '0;
        iv_ptr       = 0;
        iv_sum       = '0;
        fresh_ivs    = 0;
        last_edge_us = '0;
        edges_seen   = '0;
        cur_speed    = '0;
        cfg_dpe      = wsea_pkg::DPE_RESET;
        cfg_timeout  = wsea_pkg::TMO_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_intervals();
        test_register_extremes();
        test_random_traffic();
        test_noise();
        settle();

        $display("run covered %0d input transfers and %0d checked readings",
                 items_sent, readings_checked);
        $display("%0d window speed updates and %0d stop timeouts along the way",
                 speed_updates, timeouts_hit);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
